>>> rtl/tsss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared types, constants and helper functions of the terminal stop speed
// servo.
// ----------------------------------------------------------------------------
package tsss_pkg;

	localparam int CordicSteps = 15;
	localparam logic signed [17:0] CordicX0 = 18'sd19898;
	localparam logic signed [11:0] AccMax = 12'sd1024;
	localparam logic signed [11:0] DecMax = 12'sd1536;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_STAND = 3'd1;
	localparam logic [2:0] KIND_HEADING = 3'd2;
	localparam logic [2:0] KIND_LATERAL = 3'd3;
	localparam logic [2:0] KIND_POSE = 3'd4;

	localparam logic REG_STOP_TOL = 1'b0;
	localparam logic REG_MAX_SPEED = 1'b1;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_STAND,
		MODE_HOLD,
		MODE_SERVO
	} mode_t;

	// Per-item control and payload carried alongside the CORDIC pipeline.
	typedef struct packed {
		mode_t              mode;
		logic               active;
		logic               servo;
		logic               popt;
		logic               neg;
		logic signed [16:0] spd;
		logic signed [16:0] hold;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
	} side_t;

	function automatic logic signed [16:0] cordic_atan(input int i);
		case (i)
			0:       cordic_atan = 17'sd8192;
			1:       cordic_atan = 17'sd4836;
			2:       cordic_atan = 17'sd2555;
			3:       cordic_atan = 17'sd1297;
			4:       cordic_atan = 17'sd651;
			5:       cordic_atan = 17'sd326;
			6:       cordic_atan = 17'sd163;
			7:       cordic_atan = 17'sd81;
			8:       cordic_atan = 17'sd41;
			9:       cordic_atan = 17'sd20;
			10:      cordic_atan = 17'sd10;
			11:      cordic_atan = 17'sd5;
			12:      cordic_atan = 17'sd3;
			default: cordic_atan = 17'sd1;
		endcase
	endfunction

	// Floor of n / 5 for n below 2^22, by a reciprocal multiply.
	function automatic logic [19:0] div5(input logic [21:0] n);
		logic [41:0] p;
		p = 42'(n) * 42'd838861;
		div5 = p[41:22];
	endfunction

endpackage
`default_nettype wire

>>> rtl/tsss_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsss_cordic
// Fully pipelined CORDIC rotator, one rotation step per register stage,
// giving cosine and sine of the folded heading in Q15.
// ----------------------------------------------------------------------------
module tsss_cordic
	import tsss_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [16:0] z_in,
	output logic signed [17:0]      cos_out,
	output logic signed [17:0]      sin_out
);

	logic signed [17:0] x_sn [CordicSteps+1];
	logic signed [17:0] y_sn [CordicSteps+1];
	logic signed [16:0] z_sn [CordicSteps+1];

	assign x_sn[0] = CordicX0;
	assign y_sn[0] = '0;
	assign z_sn[0] = z_in;

	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_sn[i] >= 0) begin
					x_sn[i+1] <= x_sn[i] - (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] + (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] - cordic_atan(i);
				end else begin
					x_sn[i+1] <= x_sn[i] + (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] - (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] + cordic_atan(i);
				end
			end
		end
	end

	assign cos_out = x_sn[CordicSteps];
	assign sin_out = y_sn[CordicSteps];

endmodule
`default_nettype wire

>>> rtl/terminal_stop_speed_servo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_stop_speed_servo
// Speed and acceleration commands for the terminal stop maneuver.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle while the output is not stalled.
// Each result passes a capture stage, the 15-stage CORDIC pipeline, and
// then multiply, rounding, divide-by-five and output stages. A stall on
// the output freezes the whole pipeline, so nothing is lost or repeated.
module terminal_stop_speed_servo
	import tsss_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         maneuver_kind,
	input  wire logic               servo_tracking,
	input  wire logic               stop_point_given,
	input  wire logic signed [31:0] stop_x,
	input  wire logic signed [31:0] stop_y,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic [15:0]        heading_angle,
	input  wire logic               pose_valid,
	input  wire logic signed [16:0] speed_now,
	input  wire logic               speed_valid,
	input  wire logic signed [16:0] hold_speed,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    maneuver_active,
	output logic                    servo_active,
	output logic                    path_optional,
	output logic                    stop_required,
	output logic signed [16:0]      speed_cmd,
	output logic signed [11:0]      accel_cmd,
	output logic signed [31:0]      along_distance
);

	localparam int Depth = CordicSteps + 5;

	logic [15:0] stop_tol_q;
	logic [15:0] max_speed_q;
	logic        en;
	logic [Depth-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_tol_q <= 16'd512;
			max_speed_q <= 16'd205;
		end else if (cfg_we) begin
			if (cfg_index == REG_STOP_TOL) stop_tol_q <= cfg_data;
			if (cfg_index == REG_MAX_SPEED) max_speed_q <= cfg_data;
		end
	end

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], in_valid};
	end
	assign out_valid = vld_q[Depth-1];

	// Stage 1: decode, position differences and angle folding.
	side_t              dec;
	logic signed [16:0] z_fold;
	logic signed [16:0] z_ext;
	side_t              side_s1;
	logic signed [16:0] z_s1;

	always_comb begin
		logic base;
		base = (servo_tracking || maneuver_kind == KIND_POSE) && stop_point_given;
		dec.active = maneuver_kind != KIND_NONE;
		dec.servo = servo_tracking || maneuver_kind == KIND_POSE;
		dec.popt = base;
		dec.spd = speed_now;
		dec.hold = hold_speed;
		dec.dx = 33'(stop_x) - 33'(pos_x);
		dec.dy = 33'(stop_y) - 33'(pos_y);
		dec.mode = MODE_NONE;
		if (maneuver_kind == KIND_STAND) begin
			dec.popt = 1'b1;
			dec.mode = MODE_STAND;
		end else if (!base && (maneuver_kind == KIND_HEADING ||
				maneuver_kind == KIND_LATERAL)) begin
			dec.popt = 1'b1;
			if (speed_valid) dec.mode = MODE_HOLD;
		end else if (base && pose_valid && speed_valid) begin
			dec.mode = MODE_SERVO;
		end
		z_ext = 17'(signed'(heading_angle));
		dec.neg = 1'b0;
		z_fold = z_ext;
		if (z_ext > 17'sd16384) begin
			z_fold = z_ext - 17'sd32768;
			dec.neg = 1'b1;
		end else if (z_ext < -17'sd16384) begin
			z_fold = z_ext + 17'sd32768;
			dec.neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= dec;
			z_s1 <= z_fold;
		end
	end

	// Stages 2 to 16: CORDIC, with the item's other fields delayed alongside.
	logic signed [17:0] cos_c;
	logic signed [17:0] sin_c;
	side_t              side_sn [CordicSteps];

	tsss_cordic u_cordic (
		.clk    (clk),
		.en     (en),
		.z_in   (z_s1),
		.cos_out(cos_c),
		.sin_out(sin_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_sn[0] <= side_s1;
			for (int i = 1; i < CordicSteps; i++) side_sn[i] <= side_sn[i-1];
		end
	end

	side_t side_c;
	assign side_c = side_sn[CordicSteps-1];

	// Stage 17: projection products.
	side_t              side_s17;
	logic signed [50:0] px_s17;
	logic signed [50:0] py_s17;
	logic signed [17:0] c_use;
	logic signed [17:0] s_use;

	assign c_use = side_c.neg ? -cos_c : cos_c;
	assign s_use = side_c.neg ? -sin_c : sin_c;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s17 <= side_c;
			px_s17 <= 51'(side_c.dx) * 51'(c_use);
			py_s17 <= 51'(side_c.dy) * 51'(s_use);
		end
	end

	// Stage 18: rounding and saturation of the along-track distance.
	side_t              side_s18;
	logic signed [31:0] along_s18;
	logic signed [51:0] sum_r;
	logic signed [36:0] sh_r;
	logic signed [31:0] along_c;

	always_comb begin
		sum_r = 52'(px_s17) + 52'(py_s17) + 52'sd16384;
		sh_r = 37'(sum_r >>> 15);
		if (sh_r > 37'sd2147483647) along_c = 32'sh7FFFFFFF;
		else if (sh_r < -37'sd2147483648) along_c = 32'sh80000000;
		else along_c = sh_r[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s18 <= side_s17;
			along_s18 <= along_c;
		end
	end

	// Stage 19: tolerance check, target speed and hold acceleration.
	side_t              side_s19;
	logic signed [31:0] along_s19;
	logic               within_s19;
	logic signed [16:0] tgt_s19;
	logic signed [11:0] acc_hold_s19;
	logic [31:0]        abs_al;
	logic               big;
	logic [19:0]        q_tgt;
	logic [16:0]        mag_tgt;
	logic signed [16:0] tgt_c;
	logic signed [17:0] dh;
	logic [17:0]        dh_abs;
	logic [19:0]        q_h;
	logic signed [20:0] acc_h;
	logic signed [11:0] acc_h_cl;

	always_comb begin
		abs_al = along_s18[31] ? 32'(-33'(along_s18)) : 32'(along_s18);
		big = {2'b00, abs_al, 2'b00} >= 36'(max_speed_q) * 36'd5;
		q_tgt = div5({abs_al[19:0], 2'b00});
		mag_tgt = big ? {1'b0, max_speed_q} : q_tgt[16:0];
		tgt_c = along_s18[31] ? -signed'(mag_tgt) : signed'(mag_tgt);
		dh = 18'(side_s18.hold) - 18'(side_s18.spd);
		dh_abs = dh[17] ? 18'(-dh) : 18'(dh);
		q_h = div5(22'(dh_abs) * 22'd6);
		acc_h = dh[17] ? -21'(q_h) : 21'(q_h);
		if (acc_h > 21'(AccMax)) acc_h_cl = AccMax;
		else if (acc_h < -21'(DecMax)) acc_h_cl = -DecMax;
		else acc_h_cl = acc_h[11:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s19 <= side_s18;
			along_s19 <= along_s18;
			within_s19 <= abs_al <= 32'(stop_tol_q);
			tgt_s19 <= tgt_c;
			acc_hold_s19 <= acc_h_cl;
		end
	end

	// Stage 20: servo acceleration and result selection.
	logic signed [17:0] dt;
	logic signed [19:0] e3;
	logic signed [19:0] e2;
	logic signed [11:0] acc_s_cl;
	logic               fs_c;
	logic signed [16:0] v_c;
	logic signed [11:0] a_c;
	logic signed [31:0] al_c;

	always_comb begin
		dt = 18'(tgt_s19) - 18'(side_s19.spd);
		e3 = 20'(dt) * 20'sd3;
		// Halving toward zero: bias negative values before the shift.
		e2 = (e3 + (e3[19] ? 20'sd1 : 20'sd0)) >>> 1;
		if (e2 > 20'(AccMax)) acc_s_cl = AccMax;
		else if (e2 < -20'(DecMax)) acc_s_cl = -DecMax;
		else acc_s_cl = e2[11:0];
		fs_c = 1'b0;
		v_c = '0;
		a_c = '0;
		al_c = '0;
		case (side_s19.mode)
			MODE_STAND: fs_c = 1'b1;
			MODE_HOLD: begin
				v_c = side_s19.hold;
				a_c = acc_hold_s19;
				fs_c = side_s19.hold <= 17'sd1 && side_s19.hold >= -17'sd1;
			end
			MODE_SERVO: begin
				al_c = along_s19;
				fs_c = within_s19;
				if (!within_s19) begin
					v_c = tgt_s19;
					a_c = acc_s_cl;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			maneuver_active <= side_s19.active;
			servo_active <= side_s19.servo;
			path_optional <= side_s19.popt;
			stop_required <= fs_c;
			speed_cmd <= v_c;
			accel_cmd <= a_c;
			along_distance <= al_c;
		end
	end

`ifndef SYNTHESIS
	a_stall_map: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output back-pressure");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(along_distance) &&
		$stable(speed_cmd))
		else $error("stalled result changed");

	a_accel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accel_cmd <= AccMax && accel_cmd >= -DecMax))
		else $error("acceleration command out of range");
`endif

endmodule
`default_nettype wire

>>> test/terminal_stop_speed_servo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal stop speed servo checker
// Watches the input and output channels of the servo, computes the expected
// speed and acceleration commands for every accepted transaction and compares
// them field by field with the results in order.
// ----------------------------------------------------------------------------
module terminal_stop_speed_servo_checker
	import tsss_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [2:0]         maneuver_kind,
	input  wire logic               servo_tracking,
	input  wire logic               stop_point_given,
	input  wire logic signed [31:0] stop_x,
	input  wire logic signed [31:0] stop_y,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic [15:0]        heading_angle,
	input  wire logic               pose_valid,
	input  wire logic signed [16:0] speed_now,
	input  wire logic               speed_valid,
	input  wire logic signed [16:0] hold_speed,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic               maneuver_active,
	input  wire logic               servo_active,
	input  wire logic               path_optional,
	input  wire logic               stop_required,
	input  wire logic signed [16:0] speed_cmd,
	input  wire logic signed [11:0] accel_cmd,
	input  wire logic signed [31:0] along_distance,
	output int                      mismatches,
	output int                      pending,
	output int                      results_seen
);

	typedef struct packed {
		logic               active;
		logic               servo;
		logic               popt;
		logic               fstop;
		logic signed [16:0] vcmd;
		logic signed [11:0] acmd;
		logic signed [31:0] along;
	} command_t;

	command_t expected_cmds[$];
	logic [15:0] tol_q10;
	logic [15:0] vmax_q10;

	function automatic longint fshr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void heading_cos_sin(input logic [15:0] ang, output longint c,
			output longint s);
		longint z, x, y, nx;
		longint tab[15];
		bit neg;
		tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
		z = longint'($signed(ang));
		x = 19898;
		y = 0;
		neg = 0;
		if (z > 16384) begin
			z -= 32768;
			neg = 1;
		end else if (z < -16384) begin
			z += 32768;
			neg = 1;
		end
		for (int i = 0; i < 15; i++) begin
			if (z >= 0) begin
				nx = x - fshr(y, i);
				y = y + fshr(x, i);
				z -= tab[i];
			end else begin
				nx = x + fshr(y, i);
				y = y - fshr(x, i);
				z += tab[i];
			end
			x = nx;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic command_t servo_command();
		command_t r;
		longint spd, hold, c, s, sum, along, lim, tgt, vcmd, acmd;
		bit popt, fstop;
		spd = speed_now;
		hold = hold_speed;
		r.active = maneuver_kind != KIND_NONE;
		r.servo = servo_tracking || maneuver_kind == KIND_POSE;
		popt = r.servo && stop_point_given;
		fstop = 0;
		vcmd = 0;
		acmd = 0;
		along = 0;
		if (maneuver_kind == KIND_STAND) begin
			popt = 1;
			fstop = 1;
		end else if (!popt && (maneuver_kind == KIND_HEADING ||
				maneuver_kind == KIND_LATERAL)) begin
			popt = 1;
			if (speed_valid) begin
				vcmd = hold;
				acmd = clip(((hold - spd) * 6) / 5, -1536, 1024);
				fstop = hold <= 1 && hold >= -1;
			end
		end else if (popt && pose_valid && speed_valid) begin
			heading_cos_sin(heading_angle, c, s);
			sum = (longint'(stop_x) - longint'(pos_x)) * c +
				(longint'(stop_y) - longint'(pos_y)) * s;
			along = clip(fshr(sum + 16384, 15), -64'sd2147483648, 64'sd2147483647);
			fstop = (along < 0 ? -along : along) <= longint'(tol_q10);
			if (!fstop) begin
				lim = vmax_q10;
				tgt = clip((along * 4) / 5, -lim, lim);
				vcmd = tgt;
				acmd = clip(((tgt - spd) * 3) / 2, -1536, 1024);
			end
		end
		r.popt = popt;
		r.fstop = fstop;
		r.vcmd = vcmd[16:0];
		r.acmd = acmd[11:0];
		r.along = along[31:0];
		return r;
	endfunction

	assign pending = expected_cmds.size();

	always @(posedge clk or negedge arst_n) begin
		command_t e, a;
		if (!arst_n) begin
			tol_q10 <= 16'd512;
			vmax_q10 <= 16'd205;
			mismatches = 0;
			results_seen = 0;
			expected_cmds.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_STOP_TOL) tol_q10 <= cfg_data;
				else vmax_q10 <= cfg_data;
			end
			if (in_valid && !in_stall) expected_cmds.push_back(servo_command());
			if (out_valid && !out_stall) begin
				a = '{maneuver_active, servo_active, path_optional, stop_required,
					speed_cmd, accel_cmd, along_distance};
				results_seen++;
				if (expected_cmds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", a);
				end else begin
					e = expected_cmds.pop_front();
					if (e !== a) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch #%0d: exp act=%b srv=%b popt=%b stop=%b v=%0d a=%0d d=%0d",
								results_seen, e.active, e.servo, e.popt, e.fstop,
								e.vcmd, e.acmd, e.along);
							$display("             got act=%b srv=%b popt=%b stop=%b v=%0d a=%0d d=%0d",
								a.active, a.servo, a.popt, a.fstop, a.vcmd, a.acmd,
								a.along);
						end
					end
				end
			end
		end
	end

endmodule

>>> test/terminal_stop_speed_servo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal stop speed servo testbench
// Drives directed and random maneuver transactions with random bursts, gaps
// and output stalls across several register settings; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module terminal_stop_speed_servo_tb;
	import tsss_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = REG_STOP_TOL;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0;
	logic out_stall = 0;
	logic [2:0] maneuver_kind = KIND_NONE;
	logic servo_tracking = 0, stop_point_given = 0, pose_valid = 0, speed_valid = 0;
	logic signed [31:0] stop_x = 0, stop_y = 0, pos_x = 0, pos_y = 0;
	logic [15:0] heading_angle = 0;
	logic signed [16:0] speed_now = 0, hold_speed = 0;
	wire in_stall, out_valid, maneuver_active, servo_active, path_optional, stop_required;
	wire signed [16:0] speed_cmd;
	wire signed [11:0] accel_cmd;
	wire signed [31:0] along_distance;
	int mismatches, pending, results_seen;
	int sent = 0;
	bit long_hold = 0;

	always #5 clk = ~clk;

	terminal_stop_speed_servo dut (.*);
	terminal_stop_speed_servo_checker chk (.*);

	// Receiver stall pattern, with one long hold-off on request.
	initial begin
		int mode;
		forever begin
			if (long_hold) begin
				out_stall <= 1;
				repeat (120) @(negedge clk);
				long_hold = 0;
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(10, 60)) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic send_transaction(input logic [2:0] k, input bit trk, input bit spg,
			input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] px,
			input logic [31:0] py, input logic [15:0] hd, input bit pv,
			input logic [16:0] spd, input bit sv, input logic [16:0] hs);
		maneuver_kind <= k;
		servo_tracking <= trk;
		stop_point_given <= spg;
		stop_x <= sx;
		stop_y <= sy;
		pos_x <= px;
		pos_y <= py;
		heading_angle <= hd;
		pose_valid <= pv;
		speed_now <= spd;
		speed_valid <= sv;
		hold_speed <= hs;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// Random item, mostly a well-formed maneuver with near stop points.
	task automatic random_transaction();
		logic [31:0] px, py, sx, sy;
		logic [16:0] spd, hs;
		int r;
		px = $urandom;
		py = $urandom;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			sx = px + $signed($urandom_range(0, 8000)) - 4000;
			sy = py + $signed($urandom_range(0, 8000)) - 4000;
		end else begin
			sx = $urandom;
			sy = $urandom;
		end
		spd = 17'($urandom);
		if ($urandom_range(0, 4) == 0) hs = 17'($signed($urandom_range(0, 4)) - 2);
		else hs = 17'($urandom);
		send_transaction($urandom_range(0, 9) < 8 ? 3'($urandom_range(0, 4)) : 3'($urandom),
			$urandom_range(0, 2) == 0, $urandom_range(0, 4) != 0, sx, sy, px, py,
			16'($urandom), $urandom_range(0, 5) != 0, spd, $urandom_range(0, 5) != 0, hs);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		logic [15:0] tols[4];
		logic [15:0] vmaxes[4];
		tols = '{16'd512, 16'd0, 16'd65535, 16'd3000};
		vmaxes = '{16'd205, 16'd65535, 16'd0, 16'd1500};
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: every kind, extremes of each field, stop inside tolerance.
		send_transaction(KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_transaction(KIND_STAND, 0, 0, '1, '1, '1, '1, '1, 1, '1, 1, '1);
		send_transaction(KIND_HEADING, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 17'sd500);
		send_transaction(KIND_HEADING, 0, 0, 0, 0, 0, 0, 0, 1, -17'sd65536, 1, 17'sd65535);
		send_transaction(KIND_LATERAL, 0, 0, 0, 0, 0, 0, 0, 1, 17'sd65535, 1, -17'sd65536);
		send_transaction(KIND_LATERAL, 0, 0, 0, 0, 0, 0, 0, 1, 17'sd3, 1, 17'sd1);
		send_transaction(KIND_HEADING, 0, 0, 0, 0, 0, 0, 0, 1, 17'sd3, 1, -17'sd1);
		send_transaction(KIND_HEADING, 1, 1, 32'sd5000, 0, 0, 0, 0, 1, 0, 1, 17'sd700);
		send_transaction(KIND_POSE, 0, 1, 32'sd100, 32'sd100, 0, 0, 16'd8192, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 32'sd100000, 0, 0, 0, 0, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, -32'sd100000, 0, 0, 0, 0, 1, 17'sd300, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 16'd8192, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 16'd8192, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 0, 32'sd9000, 0, 0, 16'd32768, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 32'sd9000, 0, 0, 0, 16'd49152, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 32'sd9000, 32'sd9000, 0, 0, 16'd16385, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 32'sd9000, 32'sd9000, 0, 0, 16'd49151, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 0, 32'sd9000, 0, 0, 0, 0, 1, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 32'sd9000, 0, 0, 0, 0, 0, 0, 1, 0);
		send_transaction(KIND_POSE, 0, 1, 32'sd9000, 0, 0, 0, 0, 1, 0, 0, 0);
		send_transaction(KIND_NONE, 1, 1, 32'sd9000, 0, 0, 0, 16'hffff, 1, 0, 1, 0);
		send_transaction(3'd5, 0, 1, 0, 0, 0, 0, 0, 1, 0, 1, 17'sd100);
		send_transaction(3'd7, 1, 1, 32'sd5000, 0, 0, 0, 0, 1, 0, 1, 0);
		drain();

		// Several register settings, random traffic in bursts under each one.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_STOP_TOL, tols[ph]);
			write_reg(REG_MAX_SPEED, vmaxes[ph]);
			for (int n = 0; n < 300; n++) begin
				if (ph == 1 && n == 100) long_hold = 1;
				random_transaction();
				if ($urandom_range(0, 7) == 0) idle_gap();
			end
			drain();
		end

		$display("Covered %0d transactions and %0d results over four register settings,",
			sent, results_seen);
		$display("including a long output hold-off and random bursts and stalls.");
		if (mismatches == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
